// ----- hdl/mrmp_pkg.sv -----
// ----------------------------------------------------------------------------
// mrmp_pkg
// Shared types, constants and the CRC-16 step for the meter poller.
// ----------------------------------------------------------------------------
package mrmp_pkg;

    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 32;
    localparam int MS_W      = 16;
    localparam int POS_W     = 6;
    localparam int IDX_W     = 3;
    localparam int NUM_WORDS = 7;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    localparam logic [BYTE_W-1:0] SLAVE_RESET    = 8'h01;
    localparam logic [MS_W-1:0]   INTERVAL_RESET = 16'd2000;
    localparam logic [MS_W-1:0]   TIMEOUT_RESET  = 16'd500;
    localparam logic [MS_W-1:0]   MS_MAX         = 16'hFFFF;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [BYTE_W-1:0] FC_READ_INPUT = 8'h04;
    localparam logic [BYTE_W-1:0] REQ1_START    = 8'h00;
    localparam logic [BYTE_W-1:0] REQ1_COUNT    = 8'h16;
    localparam logic [BYTE_W-1:0] REQ2_START    = 8'h2A;
    localparam logic [BYTE_W-1:0] REQ2_COUNT    = 8'h02;
    localparam logic [BYTE_W-1:0] REP1_CNT_BYTE = 8'h2C;
    localparam logic [BYTE_W-1:0] REP2_CNT_BYTE = 8'h04;
    localparam logic [POS_W-1:0]  REP1_LEN      = 6'd49;
    localparam logic [POS_W-1:0]  REP2_LEN      = 6'd9;

    localparam logic [IDX_W-1:0] POWER_WORD = 3'd6;
    localparam logic [IDX_W-1:0] LAST_PHASE_WORD = 3'd5;

    localparam logic [1:0] REG_SLAVE    = 2'd0;
    localparam logic [1:0] REG_INTERVAL = 2'd1;
    localparam logic [1:0] REG_TIMEOUT  = 2'd2;

    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_MEAS = 1'b1;
    localparam logic REQ_TICK  = 1'b0;

    function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] v);
        logic [15:0] x;
        x = c ^ {8'h00, v};
        for (int i = 0; i < 8; i++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

endpackage

// ----- hdl/mrmp_in_if.sv -----
// ----------------------------------------------------------------------------
// mrmp_in_if
// Input channel: millisecond ticks and received bytes.
// ----------------------------------------------------------------------------
interface mrmp_in_if
    import mrmp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [BYTE_W-1:0] rx_byte;
    logic              link_up;

    modport source (output valid, output req_type, output rx_byte, output link_up,
                    input ready);
    modport sink   (input valid, input req_type, input rx_byte, input link_up,
                    output ready);
endinterface

// ----- hdl/mrmp_out_if.sv -----
// ----------------------------------------------------------------------------
// mrmp_out_if
// Result channel: transmit bytes and measurement updates.
// ----------------------------------------------------------------------------
interface mrmp_out_if
    import mrmp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              out_kind;
    logic [BYTE_W-1:0] tx_byte;
    logic [IDX_W-1:0]  meas_index;
    logic [WORD_W-1:0] meas_bits;
    logic              reply_ok;
    logic [POS_W-1:0]  reply_bytes;
    logic              last;

    modport source (output valid, output out_kind, output tx_byte, output meas_index,
                    output meas_bits, output reply_ok, output reply_bytes, output last,
                    input ready);
    modport sink   (input valid, input out_kind, input tx_byte, input meas_index,
                    input meas_bits, input reply_ok, input reply_bytes, input last,
                    output ready);
endinterface

// ----- hdl/modbus_rtu_meter_poller.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_meter_poller
// Flow: an item is processed on its transfer and sets the sequencer state;
// its first result then enters the output register, then one result per
// cycle unless the output stalls. One item per cycle is taken when it causes
// no result; one causing N (up to 14) holds the input until all are issued.
// Reset: synchronous, active low; the measurement word store is not cleared.
// ----------------------------------------------------------------------------
module modbus_rtu_meter_poller
    import mrmp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    mrmp_in_if.sink           i_in,
    mrmp_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    typedef enum logic [1:0] {PH_IDLE, PH_WAIT1, PH_WAIT2} t_phase;
    typedef enum logic [1:0] {SEQ_IDLE, SEQ_MEAS, SEQ_TX} t_seq;

    // configuration
    logic [BYTE_W-1:0] r_slave;
    logic [MS_W-1:0]   r_interval;
    logic [MS_W-1:0]   r_timeout;

    // protocol state
    t_phase            r_phase,   n_phase;
    logic [MS_W-1:0]   r_idle_el, n_idle_el;
    logic [MS_W-1:0]   r_wait_el, n_wait_el;
    logic [POS_W-1:0]  r_pos,     n_pos;
    logic [15:0]       r_crc,     n_crc;
    logic              r_hdr,     n_hdr;
    logic [POS_W-1:0]  r_count,   n_count;
    logic              r_status,  n_status;

    // word store
    logic [WORD_W-1:0] r_mem [NUM_WORDS];
    logic [WORD_W-1:0] r_rd_q;
    logic              w_cap_we;
    logic [IDX_W-1:0]  w_cap_word;
    logic [1:0]        w_cap_lane;

    // job handed to the sequencer
    logic              w_job_go;
    logic              w_job_meas;
    logic              w_job_tx;
    logic [IDX_W-1:0]  w_job_first;
    logic [IDX_W-1:0]  w_job_end;
    logic [BYTE_W-1:0] w_job_lo;
    logic [BYTE_W-1:0] w_job_cnt;

    // sequencer
    t_seq              r_seq,      n_seq;
    logic [IDX_W-1:0]  r_mi,       n_mi;
    logic [IDX_W-1:0]  r_me,       n_me;
    logic              r_tx_more,  n_tx_more;
    logic [2:0]        r_tx_pos,   n_tx_pos;
    logic [BYTE_W-1:0] r_start_lo, n_start_lo;
    logic [BYTE_W-1:0] r_cnt_lo,   n_cnt_lo;
    logic [15:0]       r_txc,      n_txc;
    logic              r_snap_ok,  n_snap_ok;
    logic [POS_W-1:0]  r_snap_n,   n_snap_n;

    // output register
    logic              r_o_valid, n_o_valid;
    logic              r_o_kind,  n_o_kind;
    logic [BYTE_W-1:0] r_o_tx,    n_o_tx;
    logic [IDX_W-1:0]  r_o_idx,   n_o_idx;
    logic [WORD_W-1:0] r_o_bits,  n_o_bits;
    logic              r_o_ok,    n_o_ok;
    logic [POS_W-1:0]  r_o_n,     n_o_n;
    logic              r_o_last,  n_o_last;

    logic              w_acc;
    logic              w_cfg_we;
    logic [1:0]        w_cfg_idx;

    // byte check
    logic [POS_W-1:0]  w_total;
    logic [BYTE_W-1:0] w_cnt_byte;
    logic [POS_W:0]    w_p2;
    logic [POS_W:0]    w_p1;
    logic              w_hdr_new;
    logic [15:0]       w_crc_new;

    assign w_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_seq == SEQ_IDLE);

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[3:2];
    assign w_cfg_we  = psel && penable && pwrite;

    always_comb begin
        unique case (w_cfg_idx)
            REG_SLAVE:    prdata = {{(APB_DW-BYTE_W){1'b0}}, r_slave};
            REG_INTERVAL: prdata = {{(APB_DW-MS_W){1'b0}}, r_interval};
            REG_TIMEOUT:  prdata = {{(APB_DW-MS_W){1'b0}}, r_timeout};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave    <= SLAVE_RESET;
            r_interval <= INTERVAL_RESET;
            r_timeout  <= TIMEOUT_RESET;
        end else if (w_cfg_we) begin
            unique case (w_cfg_idx)
                REG_SLAVE:    r_slave    <= pwdata[BYTE_W-1:0];
                REG_INTERVAL: r_interval <= pwdata[MS_W-1:0];
                REG_TIMEOUT:  r_timeout  <= pwdata[MS_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- reply byte check ----------------
    assign w_total    = (r_phase == PH_WAIT2) ? REP2_LEN : REP1_LEN;
    assign w_cnt_byte = (r_phase == PH_WAIT2) ? REP2_CNT_BYTE : REP1_CNT_BYTE;
    assign w_p2       = {1'b0, r_pos} + 7'd2;
    assign w_p1       = {1'b0, r_pos} + 7'd1;

    always_comb begin
        w_hdr_new = r_hdr;
        if (r_pos == 6'd0 && i_in.rx_byte != r_slave)       w_hdr_new = 1'b0;
        if (r_pos == 6'd1 && i_in.rx_byte != FC_READ_INPUT) w_hdr_new = 1'b0;
        if (r_pos == 6'd2 && i_in.rx_byte != w_cnt_byte)    w_hdr_new = 1'b0;
        if (w_p2 == {1'b0, w_total} && i_in.rx_byte != r_crc[7:0])  w_hdr_new = 1'b0;
        if (w_p1 == {1'b0, w_total} && i_in.rx_byte != r_crc[15:8]) w_hdr_new = 1'b0;
        w_crc_new = (w_p2 < {1'b0, w_total}) ? crc_feed(r_crc, i_in.rx_byte) : r_crc;
    end

    // capture position: word and byte lane in CDAB order
    always_comb begin
        logic [POS_W-1:0] q;
        q          = '0;
        w_cap_we   = 1'b0;
        w_cap_word = '0;
        if (r_phase == PH_WAIT1) begin
            if (r_pos >= 6'd19 && r_pos < 6'd31) begin
                q          = r_pos - 6'd19;
                w_cap_we   = 1'b1;
                w_cap_word = {1'b0, q[3:2]};
            end else if (r_pos >= 6'd35 && r_pos < 6'd47) begin
                q          = r_pos - 6'd35;
                w_cap_we   = 1'b1;
                w_cap_word = 3'd3 + {1'b0, q[3:2]};
            end
        end else if (r_phase == PH_WAIT2) begin
            if (r_pos >= 6'd3 && r_pos < 6'd7) begin
                q          = r_pos - 6'd3;
                w_cap_we   = 1'b1;
                w_cap_word = POWER_WORD;
            end
        end
        w_cap_lane = q[1:0] ^ 2'b01;
    end

    // ---------------- item processing ----------------
    always_comb begin
        logic [MS_W-1:0] el;
        el          = '0;
        n_phase     = r_phase;
        n_idle_el   = r_idle_el;
        n_wait_el   = r_wait_el;
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_hdr       = r_hdr;
        n_count     = r_count;
        n_status    = r_status;
        w_job_go    = 1'b0;
        w_job_meas  = 1'b0;
        w_job_tx    = 1'b0;
        w_job_first = '0;
        w_job_end   = '0;
        w_job_lo    = REQ1_START;
        w_job_cnt   = REQ1_COUNT;
        if (w_acc) begin
            if (i_in.req_type == REQ_TICK) begin
                if (r_phase == PH_IDLE) begin
                    el        = (r_idle_el == MS_MAX) ? r_idle_el : r_idle_el + 16'd1;
                    n_idle_el = el;
                    if (i_in.link_up && el >= r_interval) begin
                        n_count   = '0;
                        w_job_go  = 1'b1;
                        w_job_tx  = 1'b1;
                        n_phase   = PH_WAIT1;
                        n_wait_el = '0;
                        n_pos     = '0;
                        n_crc     = CRC_INIT;
                        n_hdr     = 1'b1;
                    end
                end else begin
                    el        = (r_wait_el == MS_MAX) ? r_wait_el : r_wait_el + 16'd1;
                    n_wait_el = el;
                    if (el > r_timeout) begin
                        n_phase   = PH_IDLE;
                        n_idle_el = '0;
                    end
                end
            end else if (r_phase != PH_IDLE) begin
                n_crc = w_crc_new;
                n_hdr = w_hdr_new;
                n_pos = w_p1[POS_W-1:0];
                if (r_phase == PH_WAIT1) begin
                    if (r_count < REP1_LEN) n_count = r_count + 6'd1;
                    if (w_p1 >= {1'b0, REP1_LEN}) begin
                        n_status    = w_hdr_new;
                        w_job_go    = 1'b1;
                        w_job_meas  = w_hdr_new;
                        w_job_tx    = 1'b1;
                        w_job_first = '0;
                        w_job_end   = LAST_PHASE_WORD;
                        w_job_lo    = REQ2_START;
                        w_job_cnt   = REQ2_COUNT;
                        n_phase     = PH_WAIT2;
                        n_wait_el   = '0;
                        n_pos       = '0;
                        n_crc       = CRC_INIT;
                        n_hdr       = 1'b1;
                    end
                end else if (w_p1 >= {1'b0, REP2_LEN}) begin
                    w_job_go    = w_hdr_new;
                    w_job_meas  = 1'b1;
                    w_job_first = POWER_WORD;
                    w_job_end   = POWER_WORD;
                    n_phase     = PH_IDLE;
                    n_idle_el   = '0;
                end
            end
        end
    end

    // ---------------- result sequencer ----------------
    always_comb begin
        logic slot;
        slot       = !r_o_valid || o_out.ready;
        n_seq      = r_seq;
        n_mi       = r_mi;
        n_me       = r_me;
        n_tx_more  = r_tx_more;
        n_tx_pos   = r_tx_pos;
        n_start_lo = r_start_lo;
        n_cnt_lo   = r_cnt_lo;
        n_txc      = r_txc;
        n_snap_ok  = r_snap_ok;
        n_snap_n   = r_snap_n;
        n_o_valid  = r_o_valid && !o_out.ready;
        n_o_kind   = r_o_kind;
        n_o_tx     = r_o_tx;
        n_o_idx    = r_o_idx;
        n_o_bits   = r_o_bits;
        n_o_ok     = r_o_ok;
        n_o_n      = r_o_n;
        n_o_last   = r_o_last;
        unique case (r_seq)
            SEQ_IDLE: begin
                if (w_job_go) begin
                    n_seq      = w_job_meas ? SEQ_MEAS : SEQ_TX;
                    n_mi       = w_job_first;
                    n_me       = w_job_end;
                    n_tx_more  = w_job_tx;
                    n_tx_pos   = '0;
                    n_start_lo = w_job_lo;
                    n_cnt_lo   = w_job_cnt;
                    n_txc      = CRC_INIT;
                    n_snap_ok  = n_status;
                    n_snap_n   = n_count;
                end
            end
            SEQ_MEAS: begin
                if (slot) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = KIND_MEAS;
                    n_o_tx    = '0;
                    n_o_idx   = r_mi;
                    n_o_bits  = r_rd_q;
                    n_o_ok    = r_snap_ok;
                    n_o_n     = r_snap_n;
                    n_o_last  = !r_tx_more && (r_mi == r_me);
                    if (r_mi == r_me) begin
                        n_seq = r_tx_more ? SEQ_TX : SEQ_IDLE;
                    end else begin
                        n_mi = r_mi + 3'd1;
                    end
                end
            end
            SEQ_TX: begin
                if (slot) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = KIND_TX;
                    n_o_idx   = '0;
                    n_o_bits  = '0;
                    n_o_ok    = r_snap_ok;
                    n_o_n     = r_snap_n;
                    n_o_last  = (r_tx_pos == 3'd7);
                    case (r_tx_pos)
                        3'd0:    n_o_tx = r_slave;
                        3'd1:    n_o_tx = FC_READ_INPUT;
                        3'd3:    n_o_tx = r_start_lo;
                        3'd5:    n_o_tx = r_cnt_lo;
                        3'd6:    n_o_tx = r_txc[7:0];
                        3'd7:    n_o_tx = r_txc[15:8];
                        default: n_o_tx = '0;
                    endcase
                    if (r_tx_pos < 3'd6) n_txc = crc_feed(r_txc, n_o_tx);
                    n_tx_pos = r_tx_pos + 3'd1;
                    if (r_tx_pos == 3'd7) n_seq = SEQ_IDLE;
                end
            end
            default: n_seq = SEQ_IDLE;
        endcase
    end

    // ---------------- word store ----------------
    always_ff @(posedge i_clk) begin
        if (w_acc && i_in.req_type != REQ_TICK && w_cap_we) begin
            r_mem[w_cap_word][w_cap_lane*8 +: 8] <= i_in.rx_byte;
        end
        r_rd_q <= r_mem[n_mi];
    end

    // ---------------- state and registered outputs ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_idle_el <= '0;
            r_wait_el <= '0;
            r_pos     <= '0;
            r_crc     <= CRC_INIT;
            r_hdr     <= 1'b1;
            r_count   <= '0;
            r_status  <= 1'b0;
            r_seq     <= SEQ_IDLE;
            r_mi      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_idle_el <= n_idle_el;
            r_wait_el <= n_wait_el;
            r_pos     <= n_pos;
            r_crc     <= n_crc;
            r_hdr     <= n_hdr;
            r_count   <= n_count;
            r_status  <= n_status;
            r_seq     <= n_seq;
            r_mi      <= n_mi;
            r_o_valid <= n_o_valid;
        end
        r_me       <= n_me;
        r_tx_more  <= n_tx_more;
        r_tx_pos   <= n_tx_pos;
        r_start_lo <= n_start_lo;
        r_cnt_lo   <= n_cnt_lo;
        r_txc      <= n_txc;
        r_snap_ok  <= n_snap_ok;
        r_snap_n   <= n_snap_n;
        r_o_kind   <= n_o_kind;
        r_o_tx     <= n_o_tx;
        r_o_idx    <= n_o_idx;
        r_o_bits   <= n_o_bits;
        r_o_ok     <= n_o_ok;
        r_o_n      <= n_o_n;
        r_o_last   <= n_o_last;
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.out_kind    = r_o_kind;
    assign o_out.tx_byte     = r_o_tx;
    assign o_out.meas_index  = r_o_idx;
    assign o_out.meas_bits   = r_o_bits;
    assign o_out.reply_ok    = r_o_ok;
    assign o_out.reply_bytes = r_o_n;
    assign o_out.last        = r_o_last;

endmodule

// ----- hdl/mrmp_checker.sv -----
// ----------------------------------------------------------------------------
// mrmp_checker
// Port-level checks on the poller's result channel and input ready, bound into the poller.
// ----------------------------------------------------------------------------
module mrmp_checker
    import mrmp_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic              i_out_kind,
    input logic [BYTE_W-1:0] i_out_tx,
    input logic [IDX_W-1:0]  i_out_idx,
    input logic [WORD_W-1:0] i_out_bits,
    input logic              i_out_last
);

    // stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_kind) && $stable(i_out_tx) && $stable(i_out_idx) &&
            $stable(i_out_bits) && $stable(i_out_last))
        else $error("result changed while stalled");

    // no new item while a burst is still open
    a_burst_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("input ready inside a result burst");

    // burst results follow with no gap
    a_burst_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=> i_out_valid)
        else $error("gap inside a result burst");

    // total power always closes its burst
    a_power_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == KIND_MEAS && i_out_idx == POWER_WORD |-> i_out_last)
        else $error("power update not last");

endmodule

bind modbus_rtu_meter_poller mrmp_checker u_mrmp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.out_kind),
    .i_out_tx    (o_out.tx_byte),
    .i_out_idx   (o_out.meas_index),
    .i_out_bits  (o_out.meas_bits),
    .i_out_last  (o_out.last)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the meter poller. A queue-fed driver sends
// millisecond ticks and reply bytes, built mostly as well-formed poll cycles
// with valid CRCs and some corrupted or truncated replies. An item-level
// predictor computes the request bytes and measurement updates that each
// transfer should cause. A monitor compares every result transfer in order.
// ----------------------------------------------------------------------------
module testbench;
    import mrmp_pkg::*;

    localparam logic       REQ_BYTE         = 1'b1;
    localparam logic [1:0] REG_UNUSED       = 2'd3;
    localparam int         DRAIN_CYCLES     = 20;
    localparam int         LONG_HOLD_CYCLES = 400;
    localparam int         MAX_REPORTS      = 10;
    localparam int         PHASE_ITEMS      = 60;

    typedef enum logic [1:0] {POLL_IDLE, POLL_REPLY1, POLL_REPLY2} t_poll_phase;

    typedef enum int {
        FAULT_NONE, FAULT_ADDR, FAULT_FUNC, FAULT_COUNT,
        FAULT_CRC_LO, FAULT_CRC_HI, FAULT_DATA, FAULT_SHORT
    } t_reply_fault;

    typedef enum int {DATA_RANDOM, DATA_ZEROS, DATA_ONES} t_reply_data;

    typedef struct packed {
        logic              req_type;
        logic [BYTE_W-1:0] rx_byte;
        logic              link_up;
    } t_poll_item;

    typedef struct packed {
        logic              out_kind;
        logic [BYTE_W-1:0] tx_byte;
        logic [IDX_W-1:0]  meas_index;
        logic [WORD_W-1:0] meas_bits;
        logic              reply_ok;
        logic [POS_W-1:0]  reply_bytes;
        logic              last;
    } t_poll_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    mrmp_in_if  in_ch();
    mrmp_out_if out_ch();

    modbus_rtu_meter_poller dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state and register copies
    logic [BYTE_W-1:0] cf_slave;
    logic [MS_W-1:0]   cf_interval;
    logic [MS_W-1:0]   cf_timeout;
    t_poll_phase       pr_phase;
    logic [MS_W-1:0]   pr_idle_ms;
    logic [MS_W-1:0]   pr_wait_ms;
    logic [POS_W-1:0]  pr_pos;
    logic [15:0]       pr_crc;
    logic              pr_hdr_ok;
    logic [WORD_W-1:0] pr_words [NUM_WORDS];
    logic [POS_W-1:0]  pr_reply_cnt;
    logic              pr_reply_ok;

    t_poll_item   pending_items [$];
    t_poll_result expected_results [$];
    t_poll_result step_results [$];

    int unsigned items_queued   = 0;
    int unsigned items_accepted = 0;
    int unsigned mismatch_count = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int unsigned hold_requests  = 0;
    int unsigned holds_served   = 0;
    int unsigned hold_left      = 0;
    logic [MS_W-1:0] gen_idle_ms;

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int b = 0; b < 8; b++) begin
            fb = r[0] ^ data[b];
            r  = r >> 1;
            if (fb) r = r ^ CRC_POLY;
        end
        return r;
    endfunction

    task automatic reset_predictor();
        cf_slave     = SLAVE_RESET;
        cf_interval  = INTERVAL_RESET;
        cf_timeout   = TIMEOUT_RESET;
        pr_phase     = POLL_IDLE;
        pr_idle_ms   = '0;
        pr_wait_ms   = '0;
        pr_pos       = '0;
        pr_crc       = CRC_INIT;
        pr_hdr_ok    = 1'b1;
        pr_reply_cnt = '0;
        pr_reply_ok  = 1'b0;
        foreach (pr_words[w]) pr_words[w] = '0;
    endtask

    task automatic note_result(input logic kind, input logic [7:0] tx,
                               input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] bits);
        t_poll_result r;
        r.out_kind    = kind;
        r.tx_byte     = tx;
        r.meas_index  = idx;
        r.meas_bits   = bits;
        r.reply_ok    = pr_reply_ok;
        r.reply_bytes = pr_reply_cnt;
        r.last        = 1'b0;
        step_results.push_back(r);
    endtask

    task automatic note_request(input logic [7:0] start, input logic [7:0] count);
        logic [7:0]  frame [6];
        logic [15:0] crc;
        frame = '{cf_slave, FC_READ_INPUT, 8'h00, start, 8'h00, count};
        crc   = CRC_INIT;
        foreach (frame[i]) crc = crc16_step(crc, frame[i]);
        foreach (frame[i]) note_result(KIND_TX, frame[i], '0, '0);
        note_result(KIND_TX, crc[7:0], '0, '0);
        note_result(KIND_TX, crc[15:8], '0, '0);
    endtask

    task automatic begin_reply_wait(input t_poll_phase ph);
        pr_phase   = ph;
        pr_wait_ms = '0;
        pr_pos     = '0;
        pr_crc     = CRC_INIT;
        pr_hdr_ok  = 1'b1;
    endtask

    task automatic check_reply_byte(input logic [7:0] v, input int total,
                                    input logic [7:0] count_byte);
        int p;
        p = pr_pos;
        if (p == 0 && v != cf_slave) pr_hdr_ok = 1'b0;
        if (p == 1 && v != FC_READ_INPUT) pr_hdr_ok = 1'b0;
        if (p == 2 && v != count_byte) pr_hdr_ok = 1'b0;
        if (p + 2 == total && v != pr_crc[7:0]) pr_hdr_ok = 1'b0;
        if (p + 1 == total && v != pr_crc[15:8]) pr_hdr_ok = 1'b0;
        if (p + 2 < total) pr_crc = crc16_step(pr_crc, v);
    endtask

    // CDAB wire order: bytes 0..3 land in bits 15:8, 7:0, 31:24, 23:16
    task automatic store_word_byte(input int word, input int rel, input logic [7:0] v);
        case (rel)
            0: pr_words[word][15:8]  = v;
            1: pr_words[word][7:0]   = v;
            2: pr_words[word][31:24] = v;
            default: pr_words[word][23:16] = v;
        endcase
    endtask

    task automatic predict_item(input t_poll_item it);
        int           p;
        t_poll_result r;
        step_results.delete();
        if (it.req_type == REQ_TICK) begin
            if (pr_phase == POLL_IDLE) begin
                if (pr_idle_ms != MS_MAX) pr_idle_ms++;
                if (it.link_up && pr_idle_ms >= cf_interval) begin
                    pr_reply_cnt = '0;
                    note_request(REQ1_START, REQ1_COUNT);
                    begin_reply_wait(POLL_REPLY1);
                end
            end else begin
                if (pr_wait_ms != MS_MAX) pr_wait_ms++;
                if (pr_wait_ms > cf_timeout) begin
                    pr_phase   = POLL_IDLE;
                    pr_idle_ms = '0;
                end
            end
        end else if (pr_phase == POLL_REPLY1) begin
            p = pr_pos;
            check_reply_byte(it.rx_byte, REP1_LEN, REP1_CNT_BYTE);
            if (p >= 19 && p < 31) store_word_byte((p - 19) / 4, (p - 19) % 4, it.rx_byte);
            else if (p >= 35 && p < 47)
                store_word_byte(3 + (p - 35) / 4, (p - 35) % 4, it.rx_byte);
            pr_pos = POS_W'(p + 1);
            if (pr_reply_cnt < REP1_LEN) pr_reply_cnt++;
            if (p + 1 >= REP1_LEN) begin
                pr_reply_ok = pr_hdr_ok;
                if (pr_reply_ok) begin
                    for (int w = 0; w <= LAST_PHASE_WORD; w++)
                        note_result(KIND_MEAS, 8'h00, IDX_W'(w), pr_words[w]);
                end
                note_request(REQ2_START, REQ2_COUNT);
                begin_reply_wait(POLL_REPLY2);
            end
        end else if (pr_phase == POLL_REPLY2) begin
            p = pr_pos;
            check_reply_byte(it.rx_byte, REP2_LEN, REP2_CNT_BYTE);
            if (p >= 3 && p < 7) store_word_byte(POWER_WORD, p - 3, it.rx_byte);
            pr_pos = POS_W'(p + 1);
            if (p + 1 >= REP2_LEN) begin
                if (pr_hdr_ok) note_result(KIND_MEAS, 8'h00, POWER_WORD, pr_words[POWER_WORD]);
                pr_phase   = POLL_IDLE;
                pr_idle_ms = '0;
            end
        end
        foreach (step_results[i]) begin
            r      = step_results[i];
            r.last = (i == step_results.size() - 1);
            expected_results.push_back(r);
        end
    endtask

    task automatic report_result(input string what, input t_poll_result want,
                                 input t_poll_result got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s", $realtime, what);
            $display("  exp kind=%0d tx=%02h idx=%0d bits=%08h ok=%0d bytes=%0d last=%0d",
                     want.out_kind, want.tx_byte, want.meas_index, want.meas_bits,
                     want.reply_ok, want.reply_bytes, want.last);
            $display("  got kind=%0d tx=%02h idx=%0d bits=%08h ok=%0d bytes=%0d last=%0d",
                     got.out_kind, got.tx_byte, got.meas_index, got.meas_bits,
                     got.reply_ok, got.reply_bytes, got.last);
        end
    endtask

    // input driver
    always @(posedge i_clk) begin
        t_poll_item nxt;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_item({in_ch.req_type, in_ch.rx_byte, in_ch.link_up});
                items_accepted++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = pending_items.pop_front();
                    in_ch.valid    <= 1'b1;
                    in_ch.req_type <= nxt.req_type;
                    in_ch.rx_byte  <= nxt.rx_byte;
                    in_ch.link_up  <= nxt.link_up;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_served != hold_requests) begin
            hold_left    <= LONG_HOLD_CYCLES;
            holds_served <= hold_requests;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_poll_result got;
        t_poll_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = {out_ch.out_kind, out_ch.tx_byte, out_ch.meas_index, out_ch.meas_bits,
                       out_ch.reply_ok, out_ch.reply_bytes, out_ch.last};
                if (expected_results.size() == 0) begin
                    report_result("result transfer with nothing expected", '0, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) report_result("result mismatch", want, got);
                end
            end
            out_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic push_item(input logic kind, input logic [7:0] v, input logic link);
        t_poll_item it;
        it.req_type = kind;
        it.rx_byte  = v;
        it.link_up  = link;
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic push_tick(input logic link);
        push_item(REQ_TICK, 8'($urandom_range(0, 255)), link);
    endtask

    task automatic push_byte(input logic [7:0] v);
        push_item(REQ_BYTE, v, 1'($urandom_range(0, 1)));
    endtask

    task automatic wait_drained();
        while (items_accepted != items_queued || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SLAVE:    cf_slave    = val[BYTE_W-1:0];
            REG_INTERVAL: cf_interval = val[MS_W-1:0];
            REG_TIMEOUT:  cf_timeout  = val[MS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] slave, input logic [31:0] interval,
                              input logic [31:0] timeout, input int send_pct,
                              input int recv_pct);
        apb_write(REG_SLAVE, slave);
        apb_write(REG_INTERVAL, interval);
        apb_write(REG_TIMEOUT, timeout);
        send_idle_pct  <= send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    // bring the generator in step with the block before a new set of cycles
    task automatic begin_phase();
        if (pr_phase != POLL_IDLE) begin
            repeat (int'(cf_timeout) + 1 - int'(pr_wait_ms)) push_tick(1'b0);
            gen_idle_ms = '0;
        end else begin
            gen_idle_ms = pr_idle_ms;
        end
    endtask

    task automatic queue_poll_start(input int link_down);
        int   n;
        logic link;
        n = 0;
        forever begin
            link = (n >= link_down);
            push_tick(link);
            if (gen_idle_ms != MS_MAX) gen_idle_ms++;
            n++;
            if (link && gen_idle_ms >= cf_interval) break;
        end
    endtask

    task automatic queue_reply(input logic second, input t_reply_fault fault,
                               input t_reply_data fill);
        logic [7:0]  frame [$];
        logic [7:0]  flip;
        logic [15:0] crc;
        int          len;
        int          cut;
        int          used;
        frame.push_back(cf_slave);
        frame.push_back(FC_READ_INPUT);
        frame.push_back(second ? REP2_CNT_BYTE : REP1_CNT_BYTE);
        len = second ? 4 : 44;
        repeat (len) begin
            case (fill)
                DATA_ZEROS: frame.push_back(8'h00);
                DATA_ONES:  frame.push_back(8'hFF);
                default:    frame.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        crc = CRC_INIT;
        foreach (frame[i]) crc = crc16_step(crc, frame[i]);
        frame.push_back(crc[7:0]);
        frame.push_back(crc[15:8]);
        flip = 8'($urandom_range(1, 255));
        case (fault)
            FAULT_ADDR:   frame[0] ^= flip;
            FAULT_FUNC:   frame[1] ^= flip;
            FAULT_COUNT:  frame[2] ^= flip;
            FAULT_CRC_LO: frame[frame.size() - 2] ^= flip;
            FAULT_CRC_HI: frame[frame.size() - 1] ^= flip;
            FAULT_DATA:   frame[3 + $urandom_range(0, len - 1)] ^= flip;
            default: ;
        endcase
        cut  = (fault == FAULT_SHORT) ? $urandom_range(0, frame.size() - 1) : frame.size();
        used = 0;
        for (int pos = 0; pos < cut; pos++) begin
            if (used < int'(cf_timeout) && $urandom_range(0, 15) == 0) begin
                push_tick(1'($urandom_range(0, 1)));
                used++;
            end
            push_byte(frame[pos]);
        end
        if (fault == FAULT_SHORT) begin
            repeat (int'(cf_timeout) + 1 - used) push_tick(1'($urandom_range(0, 1)));
            gen_idle_ms = '0;
        end
    endtask

    task automatic queue_poll_cycle(input t_reply_fault f1, input t_reply_fault f2,
                                    input t_reply_data fill1, input t_reply_data fill2);
        queue_poll_start($urandom_range(0, 3));
        queue_reply(1'b0, f1, fill1);
        if (f1 != FAULT_SHORT) begin
            queue_reply(1'b1, f2, fill2);
            gen_idle_ms = '0;
        end
    endtask

    function automatic t_reply_fault pick_fault();
        if ($urandom_range(0, 9) < 6) return FAULT_NONE;
        return t_reply_fault'($urandom_range(FAULT_ADDR, FAULT_SHORT));
    endfunction

    task automatic run_random_phase();
        int unsigned start;
        start = items_queued;
        begin_phase();
        while (items_queued - start < PHASE_ITEMS) begin
            repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)));
            queue_poll_cycle(pick_fault(), pick_fault(), DATA_RANDOM, DATA_RANDOM);
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_ch.valid    = 1'b0;
        in_ch.req_type = REQ_TICK;
        in_ch.rx_byte  = '0;
        in_ch.link_up  = 1'b0;
        out_ch.ready   = 1'b0;
        gen_idle_ms    = '0;
        reset_predictor();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: stray bytes and ticks far short of the poll interval
        push_byte(8'h00);
        push_byte(8'hFF);
        push_tick(1'b0);
        push_tick(1'b1);
        wait_drained();

        // default slave address, short interval, unmapped register write
        apb_write(REG_INTERVAL, 32'd1);
        apb_write(REG_TIMEOUT, 32'd4);
        apb_write(REG_UNUSED, 32'hFFFF_FFFF);
        begin_phase();
        queue_poll_cycle(FAULT_NONE, FAULT_NONE, DATA_ZEROS, DATA_ONES);
        queue_poll_cycle(t_reply_fault'($urandom_range(FAULT_ADDR, FAULT_DATA)),
                         t_reply_fault'($urandom_range(FAULT_ADDR, FAULT_DATA)),
                         DATA_ONES, DATA_ZEROS);
        wait_drained();

        // zero interval and zero timeout
        set_config(32'h0000_0000, 32'd0, 32'd0, 0, 0);
        begin_phase();
        queue_poll_cycle(FAULT_SHORT, FAULT_NONE, DATA_RANDOM, DATA_RANDOM);
        queue_poll_cycle(FAULT_NONE, FAULT_SHORT, DATA_RANDOM, DATA_RANDOM);
        wait_drained();

        // back-pressure: receiver holds off while the sender keeps offering
        set_config(32'h0000_00FF, 32'd3, 32'd12, 0, 0);
        run_random_phase();
        hold_requests <= hold_requests + 1;
        wait_drained();

        set_config($urandom_range(0, 255), $urandom_range(1, 6), $urandom_range(0, 20), 56, 0);
        run_random_phase();
        wait_drained();

        set_config($urandom_range(0, 255), $urandom_range(1, 6), $urandom_range(0, 20), 0, 56);
        run_random_phase();
        wait_drained();

        set_config($urandom_range(0, 255), 32'd1, 32'd1, 28, 28);
        run_random_phase();
        wait_drained();

        while (items_accepted != items_queued || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/mrmp_pkg.sv
hdl/mrmp_in_if.sv
hdl/mrmp_out_if.sv
hdl/modbus_rtu_meter_poller.sv
hdl/mrmp_checker.sv
tb/testbench.sv
